// ===== rtl/frame_difference_change_counter_unit_defines.svh =====
// Assertion helpers for the checker file of this block.
`ifndef FRAME_DIFFERENCE_CHANGE_COUNTER_UNIT_DEFINES_SVH
`define FRAME_DIFFERENCE_CHANGE_COUNTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fdcc_pkg.sv =====
package fdcc_pkg;

   localparam int FRAME_PIXELS_DEF = 4096;

   localparam int CNT_W   = 13;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [CNT_W-1:0] FRAME_PIXELS_RST = 13'd4096;
   localparam logic [CH_W-1:0]  THRESHOLD_RST    = 8'd102;
   localparam logic [CNT_W-1:0] LIMIT_RST        = 13'd1;
   localparam logic [CNT_W-1:0] INDEX_NONE       = 13'h1FFF;

   localparam logic ACTION_STORE   = 1'b0;
   localparam logic ACTION_COMPARE = 1'b1;

   localparam logic [1:0] REG_FRAME_PIXELS = 2'd0;
   localparam logic [1:0] REG_THRESHOLD    = 2'd1;
   localparam logic [1:0] REG_LIMIT        = 2'd2;

   typedef enum logic [1:0] {
      STATUS_STORED   = 2'd0,
      STATUS_COMPARED = 2'd1,
      STATUS_NO_REF   = 2'd2
   } status_type;

   typedef struct packed {
      logic [CNT_W-1:0] frame_pixels;
      logic [CH_W-1:0]  threshold;
      logic [CNT_W-1:0] limit;
   } cfg_type;

   // one pixel beat on its way from the input register to the accumulator
   typedef struct packed {
      logic             action;
      logic             ref_ok;
      logic             last;
      logic [CNT_W-1:0] pos;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
   } pix_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [CH_W-1:0]  max_red;
      logic [CH_W-1:0]  max_green;
      logic [CH_W-1:0]  max_blue;
      logic [CNT_W-1:0] max_index;
   } run_type;

   typedef struct packed {
      status_type       status;
      logic             triggered;
      logic [CNT_W-1:0] count;
      logic [CH_W-1:0]  max_red;
      logic [CH_W-1:0]  max_green;
      logic [CH_W-1:0]  max_blue;
      logic [CNT_W-1:0] max_index;
   } res_type;

   function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

// ===== rtl/fdcc_csr.sv =====
module fdcc_csr import fdcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_FRAME_PIXELS: cfg_in.frame_pixels = pwdata[CNT_W-1:0];
            REG_THRESHOLD:    cfg_in.threshold    = pwdata[CH_W-1:0];
            REG_LIMIT:        cfg_in.limit        = pwdata[CNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_FRAME_PIXELS: prdata = DATA_W'(cfg_ff.frame_pixels);
         REG_THRESHOLD:    prdata = DATA_W'(cfg_ff.threshold);
         REG_LIMIT:        prdata = DATA_W'(cfg_ff.limit);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_pixels <= FRAME_PIXELS_RST;
         cfg_ff.threshold    <= THRESHOLD_RST;
         cfg_ff.limit        <= LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/fdcc_ref_mem.sv =====
module fdcc_ref_mem import fdcc_pkg::*; #(
   parameter int DEPTH = FRAME_PIXELS_DEF,
   parameter int AW    = 12
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fdcc_accum.sv =====
module fdcc_accum import fdcc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pix_valid,
   input  pix_type          pix,
   input  logic [PIX_W-1:0] ref_pix,
   input  logic [CNT_W-1:0] size,
   input  logic [CH_W-1:0]  threshold,
   input  logic [CNT_W-1:0] limit,
   input  logic             rsp_ready,
   output logic             pix_taken,
   output logic             rsp_valid,
   output res_type          rsp
);

   run_type         run_ff;
   run_type         run_in;
   run_type         run_upd;
   run_type         run_clear;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   res_type         rsp_ff;
   res_type         rsp_in;
   logic [CH_W-1:0] dr;
   logic [CH_W-1:0] dg;
   logic [CH_W-1:0] db;
   logic            changed;

   assign run_clear = '{count: '0, max_red: '0, max_green: '0, max_blue: '0,
                        max_index: INDEX_NONE};

   // a last beat needs the result register free
   assign pix_taken = pix_valid && !(pix.last && rsp_valid_ff && !rsp_ready);

   assign dr = abs_diff(pix.red,   ref_pix[3*CH_W-1:2*CH_W]);
   assign dg = abs_diff(pix.green, ref_pix[2*CH_W-1:CH_W]);
   assign db = abs_diff(pix.blue,  ref_pix[CH_W-1:0]);
   assign changed = (dr > threshold) || (dg > threshold) || (db > threshold);

   always_comb begin
      run_upd = run_ff;
      if (pix.action == ACTION_COMPARE && pix.ref_ok) begin
         if (dr > run_ff.max_red) begin
            run_upd.max_red   = dr;
            run_upd.max_index = pix.pos;
         end
         if (dg > run_ff.max_green) begin
            run_upd.max_green = dg;
            run_upd.max_index = pix.pos;
         end
         if (db > run_ff.max_blue) begin
            run_upd.max_blue  = db;
            run_upd.max_index = pix.pos;
         end
         // saturate at the frame size
         if (changed && run_ff.count < size) begin
            run_upd.count = run_ff.count + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in = '{status: STATUS_STORED, triggered: 1'b0, count: '0, max_red: '0,
                 max_green: '0, max_blue: '0, max_index: INDEX_NONE};
      if (pix.action == ACTION_COMPARE) begin
         if (pix.ref_ok) begin
            rsp_in.status    = STATUS_COMPARED;
            rsp_in.triggered = (run_upd.count >= limit);
            rsp_in.count     = run_upd.count;
            rsp_in.max_red   = run_upd.max_red;
            rsp_in.max_green = run_upd.max_green;
            rsp_in.max_blue  = run_upd.max_blue;
            rsp_in.max_index = run_upd.max_index;
         end else begin
            rsp_in.status = STATUS_NO_REF;
         end
      end
   end

   always_comb begin
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pix_taken) begin
         run_in = pix.last ? run_clear : run_upd;
         if (pix.last) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= run_clear;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_taken && pix.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/frame_difference_change_counter_unit.sv =====
// Frame difference change counter. Pixels stream in one per beat on req_; the tuser bit of
// the first pixel selects store (0) or compare (1) for the whole frame, whose length is the
// frame_pixels register. A store frame fills the reference memory; a compare frame diffs
// every pixel against it and counts pixels with any channel above channel_threshold. One
// result beat per frame leaves on rsp_ via the input register and the result register.
// The block takes one pixel every clock, also while rsp_ stalls, until a second frame end
// meets a full result register: the reference memory serves one write or one read per
// pixel and the accumulator closes its loop through one run register. The memory needs no
// clearing after reset; compare before any store reports status 2 (no reference).
module frame_difference_change_counter_unit import fdcc_pkg::*; #(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic              req_tuser,   // action[0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // triggered[0], changed_count[13:1], max_red_diff[21:14], max_green_diff[29:22],
   // max_blue_diff[37:30], max_pixel_index[50:38], zero[55:51]
   output logic [55:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,   // status[1:0]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam logic [CNT_W-1:0] SIZE_LIM =
      (FRAME_PIXELS > 8191) ? 13'h1FFF : CNT_W'(FRAME_PIXELS);

   cfg_type          cfg;
   logic [CNT_W-1:0] size;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             frame_action_ff;
   logic             ref_valid_ff;
   logic             ref_valid_in;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   pix_type          s1_pix_ff;
   pix_type          pix_in;
   logic             accept;
   logic             action_now;
   logic [CNT_W-1:0] pos_ext;
   logic             last;
   logic             pix_taken;
   logic [PIX_W-1:0] ref_pix;
   res_type          rsp;

   fdcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   always_comb begin
      if (cfg.frame_pixels == '0) begin
         size = CNT_W'(1);
      end else if (32'(cfg.frame_pixels) > FRAME_PIXELS) begin
         size = SIZE_LIM;
      end else begin
         size = cfg.frame_pixels;
      end
   end

   assign req_tready = !s1_valid_ff || pix_taken;
   assign accept     = req_tvalid && req_tready;
   assign action_now = (pos_ff == '0) ? req_tuser : frame_action_ff;
   assign pos_ext    = CNT_W'(pos_ff);
   assign last       = ({1'b0, pos_ext} + 14'd1) >= {1'b0, size};

   assign pix_in = '{action: action_now, ref_ok: ref_valid_ff, last: last, pos: pos_ext,
                     red: req_tdata[7:0], green: req_tdata[15:8], blue: req_tdata[23:16]};

   always_comb begin
      pos_in       = pos_ff;
      ref_valid_in = ref_valid_ff;
      s1_valid_in  = s1_valid_ff && !pix_taken;
      if (accept) begin
         pos_in      = last ? '0 : pos_ff + 1'b1;
         s1_valid_in = 1'b1;
         if (last && action_now == ACTION_STORE) begin
            ref_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         frame_action_ff <= ACTION_STORE;
         ref_valid_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ref_valid_ff <= ref_valid_in;
         s1_valid_ff  <= s1_valid_in;
         if (accept) begin
            frame_action_ff <= action_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= pix_in;
      end
   end

   fdcc_ref_mem #(
      .DEPTH (FRAME_PIXELS),
      .AW    (POS_W)
   ) u_ref_mem (
      .clock   (clock),
      .wr_en   (accept && action_now == ACTION_STORE),
      .wr_addr (pos_ff),
      .wr_data ({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .rd_en   (accept && action_now == ACTION_COMPARE),
      .rd_addr (pos_ff),
      .rd_data (ref_pix)
   );

   fdcc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (s1_valid_ff),
      .pix       (s1_pix_ff),
      .ref_pix   (ref_pix),
      .size      (size),
      .threshold (cfg.threshold),
      .limit     (cfg.limit),
      .rsp_ready (rsp_tready),
      .pix_taken (pix_taken),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.max_index, rsp.max_blue, rsp.max_green, rsp.max_red,
                       rsp.count, rsp.triggered};
   assign rsp_tuser = rsp.status;

endmodule

// ===== rtl/fdcc_checker.sv =====
`include "frame_difference_change_counter_unit_defines.svh"

module fdcc_port_checker import fdcc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [55:0]       rsp_tdata,
   input logic [1:0]        rsp_tuser
);

   `FDCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat dropped or changed")

   `FDCC_ASSERT_NOW(a_plain_result, clock, reset,
      rsp_tvalid && rsp_tuser != STATUS_COMPARED,
      rsp_tdata[37:0] == '0 && rsp_tdata[50:38] == INDEX_NONE,
      "store or no-reference result carries comparison data")

   `FDCC_ASSERT_NOW(a_count_index, clock, reset,
      rsp_tvalid && rsp_tuser == STATUS_COMPARED && rsp_tdata[13:1] != '0,
      rsp_tdata[50:38] != INDEX_NONE, "changed pixels counted but no maximum index")

   `FDCC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid,
      "result beat valid right after reset")

endmodule

bind frame_difference_change_counter_unit fdcc_port_checker u_fdcc_port_checker (.*);

// ===== tb/fdcc_checker.sv =====
module fdcc_checker import fdcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [23:0]       req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic              req_tuser,   // action[0]
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   // triggered[0], changed_count[13:1], max_red_diff[21:14], max_green_diff[29:22],
   // max_blue_diff[37:30], max_pixel_index[50:38], zero[55:51]
   input  logic [55:0]       rsp_tdata,
   input  logic [1:0]        rsp_tuser,   // status[1:0]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                reports_waiting,
   output int                mismatches
);

   typedef struct packed {
      status_type       status;
      logic             triggered;
      logic [CNT_W-1:0] count;
      logic [CH_W-1:0]  max_red;
      logic [CH_W-1:0]  max_green;
      logic [CH_W-1:0]  max_blue;
      logic [CNT_W-1:0] max_pos;
   } frame_report_type;

   logic [PIX_W-1:0] ref_pixels [FRAME_PIXELS_DEF];
   logic             have_reference;
   logic             latched_action;
   int               beat_pos;
   logic [CNT_W-1:0] changed_tally;
   logic [CH_W-1:0]  peak_red, peak_green, peak_blue;
   logic [CNT_W-1:0] peak_pos;
   logic [CNT_W-1:0] cfg_frame_pixels;
   logic [CH_W-1:0]  cfg_threshold;
   logic [CNT_W-1:0] cfg_limit;
   frame_report_type frame_reports_due [$];
   int               mismatch_total;

   function automatic logic [CH_W-1:0] chan_gap(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // out-of-range sizes clamp to 1 and to the memory depth
   function automatic int window_size();
      if (cfg_frame_pixels == '0) return 1;
      if (cfg_frame_pixels > FRAME_PIXELS_DEF) return FRAME_PIXELS_DEF;
      return int'(cfg_frame_pixels);
   endfunction

   function automatic string show(input frame_report_type r);
      return $sformatf("status=%0d trig=%0b count=%0d max=(%0d,%0d,%0d) pos=%0d",
                       r.status, r.triggered, r.count, r.max_red, r.max_green,
                       r.max_blue, $signed(r.max_pos));
   endfunction

   task automatic restart_frame();
      beat_pos = 0;
      changed_tally = '0;
      peak_red = '0;
      peak_green = '0;
      peak_blue = '0;
      peak_pos = INDEX_NONE;
   endtask

   task automatic fold_pixel(input logic [PIX_W-1:0] px, input logic act);
      int               size;
      logic [CH_W-1:0]  dr, dg, db;
      logic [PIX_W-1:0] ref_px;
      frame_report_type rep;
      size = window_size();
      if (beat_pos == 0) latched_action = act;
      if (latched_action == ACTION_STORE) begin
         ref_pixels[beat_pos] = px;
      end else if (have_reference) begin
         ref_px = ref_pixels[beat_pos];
         dr = chan_gap(px[7:0], ref_px[7:0]);
         dg = chan_gap(px[15:8], ref_px[15:8]);
         db = chan_gap(px[23:16], ref_px[23:16]);
         if (dr > peak_red) begin
            peak_red = dr;
            peak_pos = beat_pos[CNT_W-1:0];
         end
         if (dg > peak_green) begin
            peak_green = dg;
            peak_pos = beat_pos[CNT_W-1:0];
         end
         if (db > peak_blue) begin
            peak_blue = db;
            peak_pos = beat_pos[CNT_W-1:0];
         end
         // saturate at the frame size, which can sit below the tally after a shrink
         if ((dr > cfg_threshold || dg > cfg_threshold || db > cfg_threshold) &&
             changed_tally < size)
            changed_tally = changed_tally + 1'b1;
      end
      if (beat_pos + 1 < size) begin
         beat_pos++;
      end else begin
         rep = '0;
         rep.max_pos = INDEX_NONE;
         if (latched_action == ACTION_STORE) begin
            have_reference = 1'b1;
            rep.status = STATUS_STORED;
         end else if (!have_reference) begin
            rep.status = STATUS_NO_REF;
         end else begin
            rep.status = STATUS_COMPARED;
            rep.triggered = (changed_tally >= cfg_limit);
            rep.count = changed_tally;
            rep.max_red = peak_red;
            rep.max_green = peak_green;
            rep.max_blue = peak_blue;
            rep.max_pos = peak_pos;
         end
         frame_reports_due.push_back(rep);
         restart_frame();
      end
   endtask

   task automatic check_report();
      frame_report_type got, want;
      got.status = status_type'(rsp_tuser);
      got.triggered = rsp_tdata[0];
      got.count = rsp_tdata[13:1];
      got.max_red = rsp_tdata[21:14];
      got.max_green = rsp_tdata[29:22];
      got.max_blue = rsp_tdata[37:30];
      got.max_pos = rsp_tdata[50:38];
      if (frame_reports_due.size() == 0) begin
         mismatch_total++;
         if (mismatch_total <= 10) $display("unexpected result beat: %s", show(got));
      end else begin
         want = frame_reports_due.pop_front();
         if (got.status !== want.status || got.triggered !== want.triggered ||
             got.count !== want.count || got.max_red !== want.max_red ||
             got.max_green !== want.max_green || got.max_blue !== want.max_blue ||
             got.max_pos !== want.max_pos) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("result mismatch: expected %s, actual %s", show(want), show(got));
         end
      end
   endtask

   initial mismatch_total = 0;

   always @(posedge clock) begin
      if (reset) begin
         frame_reports_due.delete();
         have_reference = 1'b0;
         latched_action = ACTION_STORE;
         cfg_frame_pixels = FRAME_PIXELS_RST;
         cfg_threshold = THRESHOLD_RST;
         cfg_limit = LIMIT_RST;
         restart_frame();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_FRAME_PIXELS: cfg_frame_pixels = csr_pwdata[CNT_W-1:0];
               REG_THRESHOLD:    cfg_threshold = csr_pwdata[CH_W-1:0];
               REG_LIMIT:        cfg_limit = csr_pwdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) fold_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_report();
      end
      reports_waiting <= frame_reports_due.size();
      mismatches <= mismatch_total;
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import fdcc_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [23:0]       req_tdata;   // red[7:0], green[15:8], blue[23:16]
   logic              req_tuser;   // action[0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // triggered[0], changed_count[13:1], max_red_diff[21:14], max_green_diff[29:22],
   // max_blue_diff[37:30], max_pixel_index[50:38], zero[55:51]
   logic [55:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;   // status[1:0]
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   int                reports_waiting;
   int                mismatches;

   logic [PIX_W-1:0]  stored_px [FRAME_PIXELS_DEF];
   logic [CNT_W-1:0]  cur_frame_pixels = FRAME_PIXELS_RST;
   logic [CH_W-1:0]   cur_threshold = THRESHOLD_RST;
   logic              steady = 1'b0;
   int                stall_left = 0;
   int                small_beats = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   frame_difference_change_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fdcc_checker u_change_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .reports_waiting (reports_waiting),
      .mismatches      (mismatches)
   );

   // result side: stall in random bursts unless running steady
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady && !reset && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int frame_len();
      if (cur_frame_pixels == '0) return 1;
      if (cur_frame_pixels > FRAME_PIXELS_DEF) return FRAME_PIXELS_DEF;
      return int'(cur_frame_pixels);
   endfunction

   // a channel value within a few steps of the threshold around the stored one
   function automatic logic [CH_W-1:0] near_value(input logic [CH_W-1:0] base);
      int span, v;
      span = int'(cur_threshold) + 2;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      return v[CH_W-1:0];
   endfunction

   task automatic send_pixel(input logic act, input logic [PIX_W-1:0] px);
      if (!steady && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off until every frame report is out and the pipeline is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_FRAME_PIXELS) cur_frame_pixels = value[CNT_W-1:0];
      else if (idx == REG_THRESHOLD) cur_threshold = value[CH_W-1:0];
   endtask

   task automatic run_frame(input logic act, input bit ramp);
      int               i, n, d;
      logic [PIX_W-1:0] px, base;
      logic             tag;
      n = frame_len();
      for (i = 0; i < n; i++) begin
         base = stored_px[i];
         if (act == ACTION_STORE) begin
            px = PIX_W'($urandom);
         end else if (ramp) begin
            // red difference grows along the frame so late pixels raise the peak
            d = i * 128 / n;
            px = base;
            px[7:0] = base[7] ? base[7:0] - d[7:0] : base[7:0] + d[7:0];
         end else if ($urandom_range(0, 2) == 0) begin
            px = PIX_W'($urandom);
         end else begin
            px = {near_value(base[23:16]), near_value(base[15:8]), near_value(base[7:0])};
         end
         tag = (i > 0 && $urandom_range(0, 9) == 0) ? ~act : act;
         send_pixel(tag, px);
         if (act == ACTION_STORE) stored_px[i] = px;
      end
   endtask

   initial begin
      int   i, phase, frames;
      logic act;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ACTION_STORE;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // compare before any reference: pixels ignored, action flip mid-frame too
      csr_write(REG_FRAME_PIXELS, 3);
      send_pixel(ACTION_COMPARE, 24'hFFFFFF);
      send_pixel(ACTION_STORE, 24'h000000);
      send_pixel(ACTION_COMPARE, 24'h5A5A5A);
      send_pixel(ACTION_STORE, 24'h000000);
      send_pixel(ACTION_STORE, 24'hFFFFFF);
      send_pixel(ACTION_STORE, 24'h0FAA55);
      // full-scale differences, then red exactly at the reset threshold
      send_pixel(ACTION_COMPARE, 24'hFFFFFF);
      send_pixel(ACTION_STORE, 24'h000000);
      send_pixel(ACTION_COMPARE, 24'h0FAABB);
      // size 0 acts as 1; limit 0 always triggers
      csr_write(REG_THRESHOLD, 0);
      csr_write(REG_LIMIT, 0);
      csr_write(REG_FRAME_PIXELS, 0);
      send_pixel(ACTION_COMPARE, 24'h000000);
      send_pixel(ACTION_STORE, 24'h000000);
      // shrink the frame mid-way so the tally sits above the new size
      csr_write(REG_LIMIT, 2);
      csr_write(REG_FRAME_PIXELS, 8);
      run_frame(ACTION_STORE, 1'b0);
      for (i = 0; i < 5; i++) send_pixel(ACTION_COMPARE, ~stored_px[i]);
      csr_write(REG_FRAME_PIXELS, 2);
      send_pixel(ACTION_COMPARE, ~stored_px[5]);

      // random part on a 64-pixel reference
      csr_write(REG_FRAME_PIXELS, 64);
      csr_write(REG_THRESHOLD, 60);
      run_frame(ACTION_STORE, 1'b0);
      phase = 0;
      while (small_beats < 1250) begin
         if (phase == 4) begin
            // one compare frame whose red difference grows along the frame
            csr_write(REG_LIMIT, $urandom_range(0, frame_len()));
            run_frame(ACTION_COMPARE, 1'b1);
            small_beats += frame_len();
         end
         case ($urandom_range(0, 7))
            0: csr_write(REG_FRAME_PIXELS, 0);
            1: csr_write(REG_FRAME_PIXELS, 1);
            2: csr_write(REG_FRAME_PIXELS, 64);
            default: csr_write(REG_FRAME_PIXELS, $urandom_range(2, 40));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(REG_THRESHOLD, 0);
               1: csr_write(REG_THRESHOLD, 255);
               default: csr_write(REG_THRESHOLD, $urandom_range(0, 255));
            endcase
         end
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(REG_LIMIT, 0);
               1: csr_write(REG_LIMIT, FRAME_PIXELS_DEF);
               2: csr_write(REG_LIMIT, 1);
               default: csr_write(REG_LIMIT, $urandom_range(0, frame_len()));
            endcase
         end
         steady = (small_beats > 1100) || ($urandom_range(0, 3) == 0);
         frames = $urandom_range(1, 6);
         repeat (frames) begin
            act = ($urandom_range(0, 3) == 0) ? ACTION_STORE : ACTION_COMPARE;
            run_frame(act, 1'b0);
            small_beats += frame_len();
         end
         phase++;
      end

      steady = 1'b1;
      drain();
      if (mismatches == 0 && reports_waiting == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
